// ===== rtl/ppdf_pkg.sv =====
// ----------------------------------------------------------------------------
// ppdf_pkg
// Shared types, codes and helpers of the permit pool with per-domain floors.
// ----------------------------------------------------------------------------
package ppdf_pkg;

   localparam int DOMAINS      = 3;
   localparam int COUNT_BITS   = 8;
   localparam int DOM_IDX_BITS = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
   localparam int FLOOR_REGS   = 3;

   localparam int OP_BITS       = 2;
   localparam int DOMAIN_BITS   = 2;
   localparam int WAKE_BITS     = 2;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 8;

   localparam logic [OP_BITS-1:0] OP_ACQUIRE    = 2'd0;
   localparam logic [OP_BITS-1:0] OP_RETRY      = 2'd1;
   localparam logic [OP_BITS-1:0] OP_RELEASE    = 2'd2;
   localparam logic [OP_BITS-1:0] OP_SET_TARGET = 2'd3;

   localparam logic [WAKE_BITS-1:0] WAKE_NONE   = 2'd0;
   localparam logic [WAKE_BITS-1:0] WAKE_ANY    = 2'd1;
   localparam logic [WAKE_BITS-1:0] WAKE_DOMAIN = 2'd2;
   localparam logic [WAKE_BITS-1:0] WAKE_ALL    = 2'd3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_POOL_ENABLE     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VARIABLE_SIZE   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOTAL_THREADS   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INITIAL_PERMITS = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLOOR_MAP       = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLOOR_FEATURE   = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLOOR_ATAC      = 3'd6;

   typedef logic [COUNT_BITS-1:0] count_type;

   localparam count_type COUNT_MAX   = {COUNT_BITS{1'b1}};
   localparam count_type COUNT_ONE   = COUNT_BITS'(1);
   localparam count_type RESET_COUNT = COUNT_ONE;

   typedef struct packed {
      logic                           pool_enable;
      logic                           variable_size_enable;
      count_type                      total_threads;
      count_type                      initial_permits;
      count_type [FLOOR_REGS-1:0]     floors;
   } cfg_type;

   typedef struct packed {
      logic      valid;
      count_type value;
   } reload_type;

   typedef struct packed {
      logic [OP_BITS-1:0]     op;
      logic [DOMAIN_BITS-1:0] domain;
      count_type              target_value;
   } item_type;

   typedef struct packed {
      logic                   granted;
      logic [WAKE_BITS-1:0]   wake_kind;
      logic [DOMAIN_BITS-1:0] wake_domain;
      count_type              available_count;
      count_type              pool_count;
      count_type              in_use_count;
   } result_type;

   function automatic count_type norm_count(input count_type total, input count_type req);
      count_type top;
      count_type r;
      top = (total == '0) ? COUNT_ONE : total;
      r   = (req == '0) ? top : req;
      if (r > top) begin
         r = top;
      end
      return r;
   endfunction

endpackage

// ===== rtl/ppdf_csr.sv =====
// ----------------------------------------------------------------------------
// ppdf_csr
// Configuration registers and pool reload on writes to the sizing registers.
// ----------------------------------------------------------------------------
module ppdf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [ppdf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ppdf_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output ppdf_pkg::cfg_type                    cfg,
   output ppdf_pkg::reload_type                 reload
);

   ppdf_pkg::cfg_type cfg_ff;
   ppdf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in       = cfg_ff;
      reload.valid = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            ppdf_pkg::CSR_POOL_ENABLE: begin
               cfg_in.pool_enable = csr_wdata[0];
               reload.valid       = 1'b1;
            end
            ppdf_pkg::CSR_VARIABLE_SIZE: begin
               cfg_in.variable_size_enable = csr_wdata[0];
               reload.valid                = 1'b1;
            end
            ppdf_pkg::CSR_TOTAL_THREADS: begin
               cfg_in.total_threads = ppdf_pkg::COUNT_BITS'(csr_wdata);
               reload.valid         = 1'b1;
            end
            ppdf_pkg::CSR_INITIAL_PERMITS: begin
               cfg_in.initial_permits = ppdf_pkg::COUNT_BITS'(csr_wdata);
               reload.valid           = 1'b1;
            end
            ppdf_pkg::CSR_FLOOR_MAP: begin
               cfg_in.floors[0] = ppdf_pkg::COUNT_BITS'(csr_wdata);
            end
            ppdf_pkg::CSR_FLOOR_FEATURE: begin
               cfg_in.floors[1] = ppdf_pkg::COUNT_BITS'(csr_wdata);
            end
            ppdf_pkg::CSR_FLOOR_ATAC: begin
               cfg_in.floors[2] = ppdf_pkg::COUNT_BITS'(csr_wdata);
            end
            default: begin
            end
         endcase
      end
      reload.value = cfg_in.pool_enable ?
                     ppdf_pkg::norm_count(cfg_in.total_threads, cfg_in.initial_permits) :
                     ppdf_pkg::norm_count(cfg_in.total_threads, '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pool_enable          <= 1'b0;
         cfg_ff.variable_size_enable <= 1'b0;
         cfg_ff.total_threads        <= ppdf_pkg::COUNT_ONE;
         cfg_ff.initial_permits      <= '0;
         cfg_ff.floors               <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/ppdf_core.sv =====
// ----------------------------------------------------------------------------
// ppdf_core
// Pool counters and the combinational admit, release and resize decision.
// ----------------------------------------------------------------------------
module ppdf_core (
   input  logic                    clock,
   input  logic                    reset,
   input  ppdf_pkg::cfg_type       cfg,
   input  ppdf_pkg::reload_type    reload,
   input  logic                    fire,
   input  ppdf_pkg::item_type      item,
   output ppdf_pkg::result_type    result
);

   localparam int N = ppdf_pkg::DOMAINS;

   ppdf_pkg::count_type free_ff;
   ppdf_pkg::count_type free_in;
   ppdf_pkg::count_type pool_ff;
   ppdf_pkg::count_type pool_in;
   ppdf_pkg::count_type in_use_ff  [N];
   ppdf_pkg::count_type in_use_in  [N];
   ppdf_pkg::count_type waiters_ff [N];
   ppdf_pkg::count_type waiters_in [N];
   ppdf_pkg::count_type floor_val  [N];

   for (genvar g = 0; g < N; g++) begin : g_floor
      if (g < ppdf_pkg::FLOOR_REGS) begin : g_reg
         assign floor_val[g] = cfg.floors[g];
      end else begin : g_zero
         assign floor_val[g] = '0;
      end
   end

   always_comb begin
      logic [ppdf_pkg::DOM_IDX_BITS-1:0] d;
      logic [N-1:0]                      below;
      logic [N-1:0]                      below_rel;
      logic [N-1:0]                      waiting;
      logic [N-1:0]                      is_d;
      logic                              fa;
      logic                              admit;
      logic                              under_found;
      logic                              most_found;
      logic [ppdf_pkg::DOM_IDX_BITS-1:0] under_idx;
      logic [ppdf_pkg::DOM_IDX_BITS-1:0] most_idx;
      ppdf_pkg::count_type               most_n;
      ppdf_pkg::count_type               rel_use;
      ppdf_pkg::count_type               tgt;
      ppdf_pkg::count_type               used;

      d = (int'(item.domain) >= N) ? '0 : ppdf_pkg::DOM_IDX_BITS'(item.domain);
      fa = 1'b0;
      for (int i = 0; i < N; i++) begin
         is_d[i]    = (d == ppdf_pkg::DOM_IDX_BITS'(i));
         below[i]   = in_use_ff[i] < floor_val[i];
         waiting[i] = (waiters_ff[i] != '0);
         fa         = fa | (floor_val[i] != '0);
      end
      fa    = fa & cfg.pool_enable;
      admit = (free_ff != '0) &&
              (!fa || ((below & is_d) != '0) || ((waiting & below & ~is_d) == '0));

      free_in = free_ff;
      pool_in = pool_ff;
      for (int i = 0; i < N; i++) begin
         in_use_in[i]  = in_use_ff[i];
         waiters_in[i] = waiters_ff[i];
      end
      result.granted     = 1'b0;
      result.wake_kind   = ppdf_pkg::WAKE_NONE;
      result.wake_domain = '0;

      under_found = 1'b0;
      most_found  = 1'b0;
      under_idx   = '0;
      most_idx    = '0;
      most_n      = '0;
      below_rel   = '0;
      rel_use     = '0;
      tgt         = ppdf_pkg::norm_count(cfg.total_threads, item.target_value);
      used        = (pool_ff > free_ff) ? pool_ff - free_ff : '0;

      case (item.op)
         ppdf_pkg::OP_ACQUIRE, ppdf_pkg::OP_RETRY: begin
            if (!cfg.pool_enable) begin
               result.granted = 1'b1;
            end else if (admit) begin
               result.granted = 1'b1;
               free_in        = free_ff - ppdf_pkg::COUNT_ONE;
               if (fa) begin
                  for (int i = 0; i < N; i++) begin
                     if (is_d[i]) begin
                        if (item.op == ppdf_pkg::OP_RETRY && waiting[i]) begin
                           waiters_in[i] = waiters_ff[i] - ppdf_pkg::COUNT_ONE;
                        end
                        if (in_use_ff[i] != ppdf_pkg::COUNT_MAX) begin
                           in_use_in[i] = in_use_ff[i] + ppdf_pkg::COUNT_ONE;
                        end
                     end
                  end
               end
            end else if (item.op == ppdf_pkg::OP_ACQUIRE && fa) begin
               for (int i = 0; i < N; i++) begin
                  if (is_d[i] && waiters_ff[i] != ppdf_pkg::COUNT_MAX) begin
                     waiters_in[i] = waiters_ff[i] + ppdf_pkg::COUNT_ONE;
                  end
               end
            end
         end
         ppdf_pkg::OP_RELEASE: begin
            if (cfg.pool_enable) begin
               if (free_ff < pool_ff) begin
                  free_in = free_ff + ppdf_pkg::COUNT_ONE;
               end
               result.wake_kind = ppdf_pkg::WAKE_ANY;
               if (fa) begin
                  for (int i = 0; i < N; i++) begin
                     rel_use = in_use_ff[i];
                     if (is_d[i] && in_use_ff[i] != '0) begin
                        rel_use      = in_use_ff[i] - ppdf_pkg::COUNT_ONE;
                        in_use_in[i] = rel_use;
                     end
                     below_rel[i] = rel_use < floor_val[i];
                  end
                  for (int i = 0; i < N; i++) begin
                     if (waiting[i]) begin
                        if (!under_found && below_rel[i]) begin
                           under_found = 1'b1;
                           under_idx   = ppdf_pkg::DOM_IDX_BITS'(i);
                        end
                        if (waiters_ff[i] > most_n) begin
                           most_found = 1'b1;
                           most_n     = waiters_ff[i];
                           most_idx   = ppdf_pkg::DOM_IDX_BITS'(i);
                        end
                     end
                  end
                  if (under_found) begin
                     result.wake_kind   = ppdf_pkg::WAKE_DOMAIN;
                     result.wake_domain = ppdf_pkg::DOMAIN_BITS'(under_idx);
                  end else if (most_found) begin
                     result.wake_kind   = ppdf_pkg::WAKE_DOMAIN;
                     result.wake_domain = ppdf_pkg::DOMAIN_BITS'(most_idx);
                  end
               end
            end
         end
         ppdf_pkg::OP_SET_TARGET: begin
            if (cfg.pool_enable && cfg.variable_size_enable && tgt != pool_ff) begin
               pool_in          = tgt;
               free_in          = (tgt > used) ? tgt - used : '0;
               result.wake_kind = ppdf_pkg::WAKE_ALL;
            end
         end
         default: begin
         end
      endcase

      result.available_count = free_in;
      result.pool_count      = pool_in;
      result.in_use_count    = (pool_in > free_in) ? pool_in - free_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= ppdf_pkg::RESET_COUNT;
         pool_ff <= ppdf_pkg::RESET_COUNT;
         for (int i = 0; i < N; i++) begin
            in_use_ff[i]  <= '0;
            waiters_ff[i] <= '0;
         end
      end else if (reload.valid) begin
         free_ff <= reload.value;
         pool_ff <= reload.value;
      end else if (fire) begin
         free_ff <= free_in;
         pool_ff <= pool_in;
         for (int i = 0; i < N; i++) begin
            in_use_ff[i]  <= in_use_in[i];
            waiters_ff[i] <= waiters_in[i];
         end
      end
   end

endmodule

// ===== rtl/permit_pool_with_domain_floors.sv =====
// ----------------------------------------------------------------------------
// permit_pool_with_domain_floors
// Counting permit pool shared by several domains with reserved floors.
//
// Request channel (req_*): one operation per transfer: acquire, retry,
// release or set target, with the domain and a target size.
// Response channel (rsp_*): exactly one transfer per request, in order,
// carrying the grant, the wake hint and the pool counters after the item.
// Configuration channel (csr_*): always ready; a transfer writes one
// register. Writes to the enable, variable-size, thread count or initial
// permit registers reload the pool size and free count.
// Timing: a request is held in an input register and its response is
// registered when it advances from there, so rsp_valid follows the
// request transfer through these two registers. Throughput: one item per
// cycle unless the receiver stalls; the counter update is combinational.
// Reset: pool and free counts go to one, domain counters to zero, the
// configuration registers to their reset values, both pipeline registers empty.
// A stalled receiver holds the response; one more request is taken into
// the input register, then req_ready drops until the response moves.
// ----------------------------------------------------------------------------
module permit_pool_with_domain_floors (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ppdf_pkg::OP_BITS-1:0]          req_op,
   input  logic [ppdf_pkg::DOMAIN_BITS-1:0]      req_domain,
   input  logic [ppdf_pkg::COUNT_BITS-1:0]       req_target_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_granted,
   output logic [ppdf_pkg::WAKE_BITS-1:0]        rsp_wake_kind,
   output logic [ppdf_pkg::DOMAIN_BITS-1:0]      rsp_wake_domain,
   output logic [ppdf_pkg::COUNT_BITS-1:0]       rsp_available_count,
   output logic [ppdf_pkg::COUNT_BITS-1:0]       rsp_pool_count,
   output logic [ppdf_pkg::COUNT_BITS-1:0]       rsp_in_use_count,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ppdf_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [ppdf_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   ppdf_pkg::cfg_type    cfg;
   ppdf_pkg::reload_type reload;
   ppdf_pkg::item_type   item_ff;
   ppdf_pkg::result_type result;
   ppdf_pkg::result_type rsp_ff;
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 req_xfer;
   logic                 advance;

   assign csr_ready = 1'b1;

   ppdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .reload    (reload)
   );

   ppdf_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .reload (reload),
      .fire   (advance),
      .item   (item_ff),
      .result (result)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff.op           <= req_op;
         item_ff.domain       <= req_domain;
         item_ff.target_value <= req_target_value;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted         = rsp_ff.granted;
   assign rsp_wake_kind       = rsp_ff.wake_kind;
   assign rsp_wake_domain     = rsp_ff.wake_domain;
   assign rsp_available_count = rsp_ff.available_count;
   assign rsp_pool_count      = rsp_ff.pool_count;
   assign rsp_in_use_count    = rsp_ff.in_use_count;

endmodule

// ===== rtl/ppdf_checker.sv =====
// ----------------------------------------------------------------------------
// ppdf_checker
// Port-level checks of the permit pool, bound to the top level.
// ----------------------------------------------------------------------------
module ppdf_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_granted,
   input logic [ppdf_pkg::WAKE_BITS-1:0]        rsp_wake_kind,
   input logic [ppdf_pkg::DOMAIN_BITS-1:0]      rsp_wake_domain,
   input logic [ppdf_pkg::COUNT_BITS-1:0]       rsp_available_count,
   input logic [ppdf_pkg::COUNT_BITS-1:0]       rsp_pool_count,
   input logic [ppdf_pkg::COUNT_BITS-1:0]       rsp_in_use_count
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted) &&
         $stable(rsp_wake_kind) && $stable(rsp_wake_domain) &&
         $stable(rsp_available_count) && $stable(rsp_pool_count) &&
         $stable(rsp_in_use_count))
      else $error("response changed while stalled");

   a_counts : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_available_count <= rsp_pool_count &&
         rsp_in_use_count == rsp_pool_count - rsp_available_count)
      else $error("pool counters inconsistent");

   a_wake_domain : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wake_kind != ppdf_pkg::WAKE_DOMAIN |-> rsp_wake_domain == '0)
      else $error("wake domain set without a domain wake");

   a_grant_no_wake : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_wake_kind == ppdf_pkg::WAKE_NONE)
      else $error("grant carries a wake hint");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind permit_pool_with_domain_floors ppdf_checker u_ppdf_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_granted         (rsp_granted),
   .rsp_wake_kind       (rsp_wake_kind),
   .rsp_wake_domain     (rsp_wake_domain),
   .rsp_available_count (rsp_available_count),
   .rsp_pool_count      (rsp_pool_count),
   .rsp_in_use_count    (rsp_in_use_count)
);

// ===== tb/sv/permit_pool_with_domain_floors_test.sv =====
// ----------------------------------------------------------------------------
// permit_pool_with_domain_floors_test
// Self-checking bench for the permit pool with per-domain floors.
//
// Drives acquire, retry, release and set-target requests through the req_
// channel and programs the pool through csr_ writes made only while the
// block is idle. A predictor that tracks pool size, free permits and the
// in-use and waiter counts of each domain computes the response of every
// accepted request. Responses are compared field by field, in order.
// Directed tests cover the disabled pool, the floor rules, and saturation
// of the counters. Random phases follow, each under a new configuration.
// The sender pauses in random gaps and the receiver stalls in shifting
// patterns.
// ----------------------------------------------------------------------------
module permit_pool_with_domain_floors_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ppdf_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [OP_BITS-1:0]       req_op = OP_ACQUIRE;
   logic [DOMAIN_BITS-1:0]   req_domain = '0;
   logic [COUNT_BITS-1:0]    req_target_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_granted;
   logic [WAKE_BITS-1:0]     rsp_wake_kind;
   logic [DOMAIN_BITS-1:0]   rsp_wake_domain;
   logic [COUNT_BITS-1:0]    rsp_available_count;
   logic [COUNT_BITS-1:0]    rsp_pool_count;
   logic [COUNT_BITS-1:0]    rsp_in_use_count;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   logic      cfg_enable;
   logic      cfg_var_size;
   count_type cfg_threads;
   count_type cfg_initial;
   count_type cfg_floor [DOMAINS];

   count_type pool_cnt;
   count_type free_cnt;
   count_type target_cnt;
   count_type dom_in_use [DOMAINS];
   count_type dom_waiters [DOMAINS];

   result_type grant_outcomes [$];
   int         fail_count = 0;
   int         burst_left = 0;
   logic [5:0] rx_phase = '0;
   logic [1:0] rx_mode = '0;

   permit_pool_with_domain_floors u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_domain          (req_domain),
      .req_target_value    (req_target_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted         (rsp_granted),
      .rsp_wake_kind       (rsp_wake_kind),
      .rsp_wake_domain     (rsp_wake_domain),
      .rsp_available_count (rsp_available_count),
      .rsp_pool_count      (rsp_pool_count),
      .rsp_in_use_count    (rsp_in_use_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("permit_pool_with_domain_floors verification failed");
      $finish;
   end

   function automatic count_type clamp_to_threads(count_type req);
      count_type top;
      count_type r;
      top = (cfg_threads == '0) ? COUNT_ONE : cfg_threads;
      r = (req == '0) ? top : req;
      if (r > top) begin
         r = top;
      end
      return r;
   endfunction

   function automatic void reload_pool_counts();
      count_type v;
      v = cfg_enable ? clamp_to_threads(cfg_initial) : clamp_to_threads('0);
      pool_cnt = v;
      free_cnt = v;
      target_cnt = v;
   endfunction

   function automatic logic floors_on();
      logic any;
      any = 1'b0;
      for (int i = 0; i < DOMAINS; i++) begin
         if (cfg_floor[i] != '0) begin
            any = 1'b1;
         end
      end
      return cfg_enable && any;
   endfunction

   function automatic logic admits(int d);
      if (free_cnt == '0) begin
         return 1'b0;
      end
      if (!floors_on()) begin
         return 1'b1;
      end
      if (dom_in_use[d] < cfg_floor[d]) begin
         return 1'b1;
      end
      for (int i = 0; i < DOMAINS; i++) begin
         if (i != d && dom_waiters[i] != '0 && dom_in_use[i] < cfg_floor[i]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic result_type apply_pool_op(logic [OP_BITS-1:0] op,
                                               logic [DOMAIN_BITS-1:0] dom,
                                               count_type tv);
      result_type r;
      logic       fa;
      int         d;
      int         under;
      int         most;
      count_type  most_n;
      count_type  t;
      count_type  used;
      r = '0;
      fa = floors_on();
      d = (dom >= DOMAINS) ? 0 : int'(dom);
      case (op)
         OP_ACQUIRE, OP_RETRY: begin
            if (!cfg_enable) begin
               r.granted = 1'b1;
            end else if (admits(d)) begin
               r.granted = 1'b1;
               free_cnt = free_cnt - 1'b1;
               if (fa) begin
                  if (op == OP_RETRY && dom_waiters[d] != '0) begin
                     dom_waiters[d] = dom_waiters[d] - 1'b1;
                  end
                  if (dom_in_use[d] != COUNT_MAX) begin
                     dom_in_use[d] = dom_in_use[d] + 1'b1;
                  end
               end
            end else if (op == OP_ACQUIRE && fa && dom_waiters[d] != COUNT_MAX) begin
               dom_waiters[d] = dom_waiters[d] + 1'b1;
            end
         end
         OP_RELEASE: begin
            if (cfg_enable) begin
               if (free_cnt < pool_cnt) begin
                  free_cnt = free_cnt + 1'b1;
               end
               r.wake_kind = WAKE_ANY;
               if (fa) begin
                  under = -1;
                  most = -1;
                  most_n = '0;
                  if (dom_in_use[d] != '0) begin
                     dom_in_use[d] = dom_in_use[d] - 1'b1;
                  end
                  for (int i = 0; i < DOMAINS; i++) begin
                     if (dom_waiters[i] != '0) begin
                        if (under < 0 && dom_in_use[i] < cfg_floor[i]) begin
                           under = i;
                        end
                        if (dom_waiters[i] > most_n) begin
                           most_n = dom_waiters[i];
                           most = i;
                        end
                     end
                  end
                  if (under < 0) begin
                     under = most;
                  end
                  if (under >= 0) begin
                     r.wake_kind = WAKE_DOMAIN;
                     r.wake_domain = DOMAIN_BITS'(under);
                  end
               end
            end
         end
         default: begin
            if (cfg_enable && cfg_var_size) begin
               t = clamp_to_threads(tv);
               target_cnt = t;
               if (t != pool_cnt) begin
                  used = (pool_cnt > free_cnt) ? pool_cnt - free_cnt : '0;
                  pool_cnt = t;
                  free_cnt = (t > used) ? t - used : '0;
                  r.wake_kind = WAKE_ALL;
               end
            end
         end
      endcase
      r.available_count = free_cnt;
      r.pool_count = pool_cnt;
      r.in_use_count = (pool_cnt > free_cnt) ? pool_cnt - free_cnt : '0;
      return r;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (grant_outcomes.size() == 0) begin
            $error("response transfer with no request outstanding");
            fail_count++;
         end else begin
            want = grant_outcomes.pop_front();
            check_field("granted", want.granted, rsp_granted);
            check_field("wake_kind", want.wake_kind, rsp_wake_kind);
            check_field("wake_domain", want.wake_domain, rsp_wake_domain);
            check_field("available_count", want.available_count, rsp_available_count);
            check_field("pool_count", want.pool_count, rsp_pool_count);
            check_field("in_use_count", want.in_use_count, rsp_in_use_count);
         end
      end
   end

   always @(posedge clock) begin
      rx_phase <= rx_phase + 1'b1;
      if (rx_phase == '0) begin
         rx_mode <= 2'($urandom_range(0, 3));
      end
      case (rx_mode)
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= rx_phase[2];
      endcase
   end

   task automatic send_item(logic [OP_BITS-1:0] op, logic [DOMAIN_BITS-1:0] dom,
                            count_type tv);
      int         gap;
      result_type expect_rsp;
      req_valid <= 1'b1;
      req_op <= op;
      req_domain <= dom;
      req_target_value <= tv;
      do @(posedge clock); while (!req_ready);
      expect_rsp = apply_pool_op(op, dom, tv);
      grant_outcomes = {grant_outcomes, expect_rsp};
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (grant_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_POOL_ENABLE: begin
            cfg_enable = data[0];
            reload_pool_counts();
         end
         CSR_VARIABLE_SIZE: begin
            cfg_var_size = data[0];
            reload_pool_counts();
         end
         CSR_TOTAL_THREADS: begin
            cfg_threads = data;
            reload_pool_counts();
         end
         CSR_INITIAL_PERMITS: begin
            cfg_initial = data;
            reload_pool_counts();
         end
         CSR_FLOOR_MAP:     cfg_floor[0] = data;
         CSR_FLOOR_FEATURE: cfg_floor[1] = data;
         CSR_FLOOR_ATAC:    cfg_floor[2] = data;
         default: ;
      endcase
   endtask

   task automatic configure(logic en, logic vs, count_type threads, count_type init,
                            count_type f0, count_type f1, count_type f2);
      settle();
      write_reg(CSR_POOL_ENABLE, {7'd0, en});
      write_reg(CSR_VARIABLE_SIZE, {7'd0, vs});
      write_reg(CSR_TOTAL_THREADS, threads);
      write_reg(CSR_INITIAL_PERMITS, init);
      write_reg(CSR_FLOOR_MAP, f0);
      write_reg(CSR_FLOOR_FEATURE, f1);
      write_reg(CSR_FLOOR_ATAC, f2);
      csr_valid <= 1'b0;
   endtask

   task automatic test_disabled();
      send_item(OP_ACQUIRE, 2'd0, 8'd0);
      send_item(OP_RETRY, 2'd1, 8'd7);
      send_item(OP_RELEASE, 2'd2, 8'd0);
      send_item(OP_SET_TARGET, 2'd3, 8'd255);
   endtask

   task automatic test_floor_rules();
      configure(1'b1, 1'b1, 8'd4, 8'd2, 8'd1, 8'd1, 8'd0);
      send_item(OP_ACQUIRE, 2'd0, 8'd0);
      send_item(OP_ACQUIRE, 2'd1, 8'd0);
      send_item(OP_ACQUIRE, 2'd2, 8'd0);
      send_item(OP_ACQUIRE, 2'd0, 8'd0);
      send_item(OP_RETRY, 2'd2, 8'd0);
      send_item(OP_RELEASE, 2'd0, 8'd0);
      send_item(OP_RETRY, 2'd0, 8'd0);
      send_item(OP_SET_TARGET, 2'd1, 8'd4);
      send_item(OP_SET_TARGET, 2'd1, 8'd4);
      send_item(OP_SET_TARGET, 2'd2, 8'd0);
      send_item(OP_SET_TARGET, 2'd0, 8'd255);
      send_item(OP_SET_TARGET, 2'd0, 8'd1);
      send_item(OP_RELEASE, 2'd1, 8'd0);
      send_item(OP_RELEASE, 2'd3, 8'd0);
      send_item(OP_RELEASE, 2'd2, 8'd0);
   endtask

   task automatic test_floor_blocking();
      configure(1'b1, 1'b0, 8'd2, 8'd0, 8'd2, 8'd0, 8'd0);
      send_item(OP_ACQUIRE, 2'd1, 8'd0);
      send_item(OP_ACQUIRE, 2'd1, 8'd0);
      send_item(OP_ACQUIRE, 2'd0, 8'd0);
      send_item(OP_RELEASE, 2'd1, 8'd0);
      send_item(OP_ACQUIRE, 2'd1, 8'd0);
      send_item(OP_SET_TARGET, 2'd1, 8'd3);
      send_item(OP_RETRY, 2'd0, 8'd0);
   endtask

   task automatic test_waiter_saturation();
      configure(1'b1, 1'b1, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0);
      send_item(OP_ACQUIRE, 2'd0, 8'd0);
      repeat (260) send_item(OP_ACQUIRE, 2'd1, 8'($urandom_range(0, 255)));
      send_item(OP_RELEASE, 2'd1, 8'd0);
      send_item(OP_RELEASE, 2'd0, 8'd0);
      send_item(OP_RETRY, 2'd1, 8'd0);
   endtask

   task automatic test_in_use_saturation();
      configure(1'b1, 1'b0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255);
      repeat (256) send_item(OP_ACQUIRE, 2'd2, 8'($urandom_range(0, 255)));
      settle();
      write_reg(CSR_INITIAL_PERMITS, 8'd255);
      csr_valid <= 1'b0;
      send_item(OP_ACQUIRE, 2'd2, 8'd0);
      send_item(OP_RELEASE, 2'd2, 8'd0);
      send_item(OP_RELEASE, 2'd0, 8'd0);
   endtask

   function automatic count_type pick_floor();
      case ($urandom_range(0, 7))
         0, 1, 2: return '0;
         7:       return COUNT_MAX;
         default: return count_type'($urandom_range(1, 4));
      endcase
   endfunction

   task automatic test_random(int phases, int items);
      logic                   en;
      logic                   vs;
      count_type              threads;
      count_type              init;
      count_type              tv;
      logic [OP_BITS-1:0]     op;
      logic [DOMAIN_BITS-1:0] dom;
      int                     pick;
      for (int p = 0; p < phases; p++) begin
         en = ($urandom_range(0, 7) != 0);
         vs = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0:       threads = '0;
            1:       threads = COUNT_MAX;
            2:       threads = count_type'($urandom_range(9, 254));
            default: threads = count_type'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 5))
            0:       init = '0;
            1:       init = COUNT_MAX;
            default: init = count_type'($urandom_range(0, 10));
         endcase
         if (p % 4 == 3) begin
            configure(en, vs, threads, init, '0, '0, '0);
         end else begin
            configure(en, vs, threads, init, pick_floor(), pick_floor(), pick_floor());
         end
         repeat (items) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               op = OP_ACQUIRE;
            end else if (pick < 6) begin
               op = OP_RETRY;
            end else if (pick < 9) begin
               op = OP_RELEASE;
            end else begin
               op = OP_SET_TARGET;
            end
            dom = DOMAIN_BITS'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
               0:       tv = '0;
               1:       tv = COUNT_MAX;
               2, 3:    tv = count_type'($urandom_range(1, 10));
               default: tv = count_type'($urandom_range(0, 255));
            endcase
            send_item(op, dom, tv);
         end
      end
   endtask

   initial begin
      cfg_enable = 1'b0;
      cfg_var_size = 1'b0;
      cfg_threads = RESET_COUNT;
      cfg_initial = '0;
      for (int i = 0; i < DOMAINS; i++) begin
         cfg_floor[i] = '0;
         dom_in_use[i] = '0;
         dom_waiters[i] = '0;
      end
      reload_pool_counts();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_disabled();
      test_floor_rules();
      test_floor_blocking();
      test_waiter_saturation();
      test_in_use_saturation();
      test_random(8, 140);
      settle();
      if (fail_count == 0) begin
         $display("permit_pool_with_domain_floors verification clean");
      end else begin
         $display("permit_pool_with_domain_floors verification failed");
      end
      $finish;
   end

endmodule

// ===== permit_pool_with_domain_floors.f =====
rtl/ppdf_pkg.sv
rtl/ppdf_csr.sv
rtl/ppdf_core.sv
rtl/permit_pool_with_domain_floors.sv
rtl/ppdf_checker.sv
tb/sv/permit_pool_with_domain_floors_test.sv
